@@ design/assert_macros.svh @@
// assertion macros used by the decoder rtl file
// each macro samples on clk; the first one is held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// types, constants and byte classification for the utf-8 byte stream decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 16;
  localparam int PEND_W  = 2;
  localparam int CONT_W  = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [PEND_W-1:0] pend_t;

  localparam byte_t ASCII_MASK = 8'h80;
  localparam byte_t LEAD2_MASK = 8'hE0;
  localparam byte_t LEAD2_CODE = 8'hC0;
  localparam byte_t LEAD2_DATA = 8'h1F;
  localparam byte_t LEAD3_MASK = 8'hF0;
  localparam byte_t LEAD3_CODE = 8'hE0;
  localparam byte_t LEAD3_DATA = 8'h0F;

  localparam pend_t PEND_NONE  = 2'd0;
  localparam pend_t PEND_LEAD2 = 2'd1;
  localparam pend_t PEND_LEAD3 = 2'd2;
  localparam pend_t PEND_BAD   = 2'd3;

  typedef enum logic [1:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_SKIP
  } byte_kind_t;

  function automatic byte_kind_t classify(input byte_t b);
    byte_kind_t k;
    if ((b & ASCII_MASK) == '0) begin
      k = KIND_ASCII;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      k = KIND_LEAD2;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      k = KIND_LEAD3;
    end else begin
      k = KIND_SKIP;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ design/u8d_in_if.sv @@
// ----------------------------------------------------------------------------
// u8d_in_if
// byte channel into the decoder: valid, ready, text byte and final flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface u8d_in_if;
  logic            valid;
  logic            ready;
  u8d_pkg::byte_t  text_byte;
  logic            final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ design/u8d_out_if.sv @@
// ----------------------------------------------------------------------------
// u8d_out_if
// result channel out of the decoder: valid, ready and one decoded result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface u8d_out_if;
  logic          valid;
  logic          ready;
  u8d_pkg::cp_t  code_point;
  logic          char_ready;
  logic          end_of_text;

  modport source (output valid, output code_point, output char_ready,
                  output end_of_text, input ready);
  modport sink   (input valid, input code_point, input char_ready,
                  input end_of_text, output ready);
endinterface

`default_nettype wire

@@ design/utf8_byte_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// decodes one-, two- and three-byte utf-8 into 16-bit code points, one
// result per input byte
// ----------------------------------------------------------------------------
// each accepted byte's result is registered in the output register
// throughput: 1 byte per cycle; the output register refills in the cycle
//   its result transfers, so a stall only holds when out_ch.ready is low
// reset: synchronous active-low rst_n clears the pending count, the partial
//   code point and the output valid flag
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8_byte_stream_decoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  u8d_in_if.sink     in_ch,
  u8d_out_if.source  out_ch
);

  u8d_pkg::pend_t pend_r;
  u8d_pkg::pend_t pend_nxt;
  u8d_pkg::cp_t   part_r;
  u8d_pkg::cp_t   part_nxt;
  u8d_pkg::cp_t   part_cont;
  u8d_pkg::cp_t   point;
  logic           ready_chr;

  logic           out_valid_r;
  u8d_pkg::cp_t   code_point_r;
  logic           char_ready_r;
  logic           end_of_text_r;

  logic           in_fire;
  logic           out_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // decode step
  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    ready_chr = 1'b0;
    point     = '0;
    part_cont = {part_r[u8d_pkg::CP_W-u8d_pkg::CONT_W-1:0],
                 in_ch.text_byte[u8d_pkg::CONT_W-1:0]};
    if (pend_r != u8d_pkg::PEND_NONE) begin
      pend_nxt = pend_r - u8d_pkg::PEND_LEAD2;
      if (pend_nxt == u8d_pkg::PEND_NONE) begin
        ready_chr = 1'b1;
        point     = part_cont;
        part_nxt  = '0;
      end else begin
        part_nxt  = part_cont;
      end
    end else begin
      unique case (u8d_pkg::classify(in_ch.text_byte))
        u8d_pkg::KIND_ASCII: begin
          ready_chr = 1'b1;
          point     = u8d_pkg::cp_t'(in_ch.text_byte);
        end
        u8d_pkg::KIND_LEAD2: begin
          part_nxt = u8d_pkg::cp_t'(in_ch.text_byte & u8d_pkg::LEAD2_DATA);
          pend_nxt = u8d_pkg::PEND_LEAD2;
        end
        u8d_pkg::KIND_LEAD3: begin
          part_nxt = u8d_pkg::cp_t'(in_ch.text_byte & u8d_pkg::LEAD3_DATA);
          pend_nxt = u8d_pkg::PEND_LEAD3;
        end
        default: begin
        end
      endcase
    end
    // a cut-off sequence at the end of text is dropped
    if (in_ch.final_byte) begin
      pend_nxt = u8d_pkg::PEND_NONE;
      part_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= u8d_pkg::PEND_NONE;
      part_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_r      <= pend_nxt;
        part_r      <= part_nxt;
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      code_point_r  <= point;
      char_ready_r  <= ready_chr;
      end_of_text_r <= in_ch.final_byte;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_point  = code_point_r;
  assign out_ch.char_ready  = char_ready_r;
  assign out_ch.end_of_text = end_of_text_r;

  `ASSERT_CLK(a_pend_never_bad, pend_r != u8d_pkg::PEND_BAD, "pending count reached three")
  `ASSERT_CLK(a_final_clears, (in_fire && in_ch.final_byte) |=> (pend_r == u8d_pkg::PEND_NONE && part_r == '0), "state not cleared after final byte")
  `ASSERT_CLK(a_fire_loads, in_fire |=> out_valid_r, "accepted byte left no result")
  `ASSERT_CLK(a_no_char_zero, (out_valid_r && !char_ready_r) |-> (code_point_r == '0), "code point set without char_ready")

endmodule

`default_nettype wire
